FILE: rtl/dpxh_pkg.sv
// shared types, constants and codes of the dpx histogram accumulator
package dpxh_pkg;

    localparam int NUM_COLS   = 4096;
    localparam int NUM_ROWS   = 256;
    localparam int COUNT_BITS = 32;

    localparam int COL_W  = $clog2(NUM_COLS);
    localparam int ROW_W  = $clog2(NUM_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;

    localparam logic [1:0] CMD_ACC   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] CFG_SEGMENT_MODE   = 3'd0;
    localparam logic [2:0] CFG_X_ORIGIN       = 3'd1;
    localparam logic [2:0] CFG_X_STEP         = 3'd2;
    localparam logic [2:0] CFG_X_STEP_INVERSE = 3'd3;
    localparam logic [2:0] CFG_Y_LOW          = 3'd4;
    localparam logic [2:0] CFG_Y_SCALE        = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] sample;
        logic               first_of_trace;
        logic [7:0]         read_row;
        logic [11:0]        read_column;
    } t_in_item;

    typedef struct packed {
        logic [31:0] cell_count;
        logic [31:0] column_total;
        logic [12:0] cells_hit;
    } t_out_item;

    typedef struct packed {
        logic             rd;
        logic             inc;
        logic             clr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_store_ctl;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_PT_CHK, S_SG_INIT, S_SG_T, S_SG_Y, S_SG_A, S_SG_R,
        S_RD, S_WR, S_CLR, S_DONE
    } t_state;

endpackage

FILE: rtl/dpxh_store.sv
// hit store and column weight memories with saturating read-modify-write
module dpxh_store (
    input  logic                           i_clk,
    input  dpxh_pkg::t_store_ctl           i_ctl,
    output logic [dpxh_pkg::COUNT_BITS-1:0] o_cell_q,
    output logic [dpxh_pkg::COUNT_BITS-1:0] o_colw_q
);
    import dpxh_pkg::*;

    logic [COUNT_BITS-1:0] r_cell_mem [NUM_COLS*NUM_ROWS];
    logic [COUNT_BITS-1:0] r_colw_mem [NUM_COLS];
    logic [COUNT_BITS-1:0] r_cell_q;
    logic [COUNT_BITS-1:0] r_colw_q;
    logic [ADDR_W-1:0]     w_addr;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    assign w_addr = {i_ctl.row, i_ctl.col};

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_cell_q <= r_cell_mem[w_addr];
            r_colw_q <= r_colw_mem[i_ctl.col];
        end
    end

    // write back uses the data read in the previous cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_cell_mem[w_addr]    <= '0;
            r_colw_mem[i_ctl.col] <= '0;
        end else if (i_ctl.inc) begin
            r_cell_mem[w_addr]    <= sat_inc(r_cell_q);
            r_colw_mem[i_ctl.col] <= sat_inc(r_colw_q);
        end
    end

    assign o_cell_q = r_cell_q;
    assign o_colw_q = r_colw_q;

endmodule

FILE: rtl/dpx_histogram_accumulator_core.sv
// top level of the dpx histogram accumulator: command sequencer and datapath
//
// Input items arrive on i_in_valid / o_in_stall with i_in_data; cmd selects
// accumulate (bin one trace sample), read one cell, or clear the store.
// Every input transaction gives exactly one output transaction on
// o_out_valid / i_out_stall. Registers are written over i_cfg_valid /
// o_cfg_ready, by the user only while the block is idle; the block never checks.
// Items are handled one at a time; each increment is a read followed by
// a write back in the next cycle through the single port of each memory.
// Point accumulate: grid check, read and write; no access when the sample
// misses the grid. Segment accumulate: span set-up, then per column drawn
// t multiply, row multiplies, read, write; nothing when the trace restarts.
// Read: one read; unused command: zero result. Clear: one store entry per cycle.
// After reset a clearing pass runs over all 2^20 store entries; o_in_stall
// stays high until it is done. Configuration writes are taken at any time.
// A finished result waits in the output register while the receiver stalls;
// the next item is still taken meanwhile, and the one after that waits until
// the output register is free.
module dpx_histogram_accumulator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dpxh_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dpxh_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import dpxh_pkg::*;

    localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;

    t_state r_state, n_state;
    t_in_item r_item;
    t_out_item r_out;
    logic r_out_valid;

    logic               r_seg_mode;
    logic signed [31:0] r_x_origin;
    logic [30:0]        r_x_step;
    logic [30:0]        r_x_inv;
    logic signed [15:0] r_y_low;
    logic [30:0]        r_y_scale;

    logic signed [39:0] r_pos, r_x0;
    logic signed [15:0] r_prev, r_y0;
    logic               r_have;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col, r_last;
    logic [46:0]        r_prod_pt;
    logic               r_pt_neg;
    logic               r_tz, r_to;
    logic [62:0]        r_p;
    logic signed [34:0] r_dyt;
    logic [63:0]        r_ap;
    logic               r_a_neg;
    logic [12:0]        r_hits;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_clr_out;

    logic w_in_acc, w_restart, w_out_free;
    logic signed [40:0] w_sum;
    logic signed [39:0] w_pos_next;
    logic signed [16:0] w_pt_a;
    logic               w_col_ok, w_row_ok;
    logic [COL_W-1:0]   w_pt_col;
    logic [ROW_W-1:0]   w_pt_row;
    logic [30:0]        w_rowv;
    logic signed [40:0] w_ceil_sum;
    logic signed [25:0] w_first, w_last_raw, w_last;
    logic               w_empty;
    logic signed [41:0] w_diff;
    logic [46:0]        w_pq;
    logic [16:0]        w_t;
    logic signed [16:0] w_dy, w_base;
    logic signed [35:0] w_a;
    logic [31:0]        w_row_hi;
    logic [ROW_W-1:0]   w_sg_row;
    t_store_ctl         w_ctl;
    logic [COUNT_BITS-1:0] w_cell_q, w_colw_q;

    dpxh_store u_store (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .o_cell_q (w_cell_q),
        .o_colw_q (w_colw_q)
    );

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_restart  = r_item.first_of_trace || !r_have;

    // saturating position advance
    assign w_sum      = {r_pos[39], r_pos} + 41'(r_x_step);
    assign w_pos_next = (!w_sum[40] && w_sum[39]) ? POS_MAX : w_sum[39:0];

    // point binning
    assign w_pt_a   = 17'(r_item.sample) - 17'(r_y_low);
    assign w_rowv   = r_prod_pt[46:16];
    assign w_col_ok = !r_pos[39] && ((r_pos[39:16] < 24'(NUM_COLS)) ||
                      (r_pos[39:16] == 24'(NUM_COLS) && r_pos[15:0] == 16'd0));
    assign w_pt_col = (r_pos[39:16] == 24'(NUM_COLS)) ? COL_W'(NUM_COLS - 1)
                                                      : r_pos[16 +: COL_W];
    assign w_row_ok = !r_pt_neg && ((w_rowv < 31'(NUM_ROWS)) ||
                      (w_rowv == 31'(NUM_ROWS) && r_prod_pt[15:0] == 16'd0));
    assign w_pt_row = (w_rowv == 31'(NUM_ROWS)) ? ROW_W'(NUM_ROWS - 1)
                                                : w_rowv[ROW_W-1:0];

    // segment column span, clamped into the grid
    assign w_ceil_sum = {r_pos[39], r_pos} + 41'sh0_FFFF;
    assign w_first    = r_x0[39] ? 26'sd0 : 26'($signed(r_x0[39:16]));
    assign w_last_raw = (r_pos > r_x0) ? 26'($signed(w_ceil_sum[40:16]))
                                       : 26'($signed(r_pos[39:16]));
    assign w_last     = (w_last_raw > 26'sd0 + 26'(NUM_COLS - 1))
                        ? 26'(NUM_COLS - 1) : w_last_raw;
    assign w_empty    = w_last < w_first;

    // interpolation parameter and row
    assign w_diff = $signed(42'(r_col) << 16) - $signed({{2{r_x0[39]}}, r_x0});
    assign w_pq   = r_p[62:16];
    assign w_t    = r_tz ? 17'd0 :
                    (r_to || w_pq > 47'h1_0000) ? 17'h1_0000 : w_pq[16:0];
    assign w_dy   = 17'(r_item.sample) - 17'(r_y0);
    assign w_base = 17'(r_y0) - 17'(r_y_low);
    assign w_a    = $signed({{3{w_base[16]}}, w_base, 16'd0}) + 36'(r_dyt);
    assign w_row_hi = r_ap[63:32];
    assign w_sg_row = r_a_neg ? '0 :
                      (w_row_hi >= 32'(NUM_ROWS)) ? ROW_W'(NUM_ROWS - 1)
                                                  : w_row_hi[ROW_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.cmd)
                        CMD_ACC:   n_state = S_ACC;
                        CMD_READ:  n_state = S_RD;
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_ACC: begin
                if (!r_seg_mode)    n_state = S_PT_CHK;
                else if (w_restart) n_state = S_DONE;
                else                n_state = S_SG_INIT;
            end
            S_PT_CHK:  n_state = (w_col_ok && w_row_ok) ? S_RD : S_DONE;
            S_SG_INIT: n_state = w_empty ? S_DONE : S_SG_T;
            S_SG_T:    n_state = S_SG_Y;
            S_SG_Y:    n_state = S_SG_A;
            S_SG_A:    n_state = S_SG_R;
            S_SG_R:    n_state = S_RD;
            S_RD:      n_state = (r_item.cmd == CMD_READ) ? S_DONE : S_WR;
            S_WR:      n_state = (r_seg_mode && r_col != r_last) ? S_SG_T : S_DONE;
            S_CLR: begin
                if (r_clr_addr == '1) n_state = r_clr_out ? S_DONE : S_IDLE;
            end
            S_DONE:    n_state = w_out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_ctl.rd   = (r_state == S_RD);
        w_ctl.inc  = (r_state == S_WR);
        w_ctl.clr  = (r_state == S_CLR);
        w_ctl.row  = (r_state == S_CLR) ? r_clr_addr[ADDR_W-1:COL_W] : r_row;
        w_ctl.col  = (r_state == S_CLR) ? r_clr_addr[COL_W-1:0] : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_out   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_hits      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_hits     <= '0;
                r_clr_addr <= '0;
                r_clr_out  <= (i_in_data.cmd == CMD_CLEAR);
            end
            if (r_state == S_CLR) r_clr_addr <= r_clr_addr + 1'b1;
            if (r_state == S_ACC) begin
                r_pos  <= w_restart ? 40'(r_x_origin) : w_pos_next;
                r_prev <= r_item.sample;
                r_have <= 1'b1;
            end
            if (r_state == S_WR) r_hits <= r_hits + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_mode <= 1'b0;
            r_x_origin <= '0;
            r_x_step   <= 31'h1_0000;
            r_x_inv    <= 31'h1_0000;
            r_y_low    <= 16'sh8000;
            r_y_scale  <= 31'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SEGMENT_MODE:   r_seg_mode <= i_cfg_data[0];
                CFG_X_ORIGIN:       r_x_origin <= i_cfg_data;
                CFG_X_STEP:         r_x_step   <= i_cfg_data[30:0];
                CFG_X_STEP_INVERSE: r_x_inv    <= i_cfg_data[30:0];
                CFG_Y_LOW:          r_y_low    <= i_cfg_data[15:0];
                CFG_Y_SCALE:        r_y_scale  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_item <= i_in_data;
                    r_row  <= i_in_data.read_row;
                    r_col  <= i_in_data.read_column;
                end
            end
            S_ACC: begin
                r_x0      <= r_pos;
                r_y0      <= r_prev;
                r_pt_neg  <= w_pt_a[16];
                r_prod_pt <= 47'(w_pt_a[15:0] * r_y_scale);
            end
            S_PT_CHK: begin
                r_row <= w_pt_row;
                r_col <= w_pt_col;
            end
            S_SG_INIT: begin
                r_col  <= w_first[COL_W-1:0];
                r_last <= w_last[COL_W-1:0];
            end
            S_SG_T: begin
                r_tz <= (w_diff <= 42'sd0) || (r_x_inv == '0);
                r_to <= (w_diff >= 42'sh1_0000_0000);
                r_p  <= 63'(w_diff[31:0] * r_x_inv);
            end
            S_SG_Y:  r_dyt <= 35'(w_dy * $signed({1'b0, w_t}));
            S_SG_A: begin
                r_a_neg <= w_a[35];
                r_ap    <= 64'(w_a[32:0] * r_y_scale);
            end
            S_SG_R:  r_row <= w_sg_row;
            S_WR: begin
                if (r_col != r_last) r_col <= r_col + 1'b1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out.cell_count   <= (r_item.cmd == CMD_READ) ? 32'(w_cell_q) : 32'd0;
                    r_out.column_total <= (r_item.cmd == CMD_READ) ? 32'(w_colw_q) : 32'd0;
                    r_out.cells_hit    <= (r_item.cmd == CMD_ACC) ? r_hits : 13'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_inc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.inc |-> $past(w_ctl.rd))
        else $error("write back without a preceding read");

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= 13'(NUM_COLS))
        else $error("cells hit exceeds column count");

    a_wr_only_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_item.cmd == CMD_ACC))
        else $error("store increment outside an accumulate transaction");

endmodule
